FILE: hdl/mcp_pkg.sv
// Package for the capture cell parser: result record, kind and error codes,
// stream constants and the header tag table. No dependencies.
`default_nettype none

package mcp_pkg;

    typedef logic [1:0] t_kind;
    typedef logic [1:0] t_err;

    localparam t_kind KIND_EVENT      = 2'd0;
    localparam t_kind KIND_NAME_BYTE  = 2'd1;
    localparam t_kind KIND_EMPTY_NAME = 2'd2;
    localparam t_kind KIND_ERROR      = 2'd3;

    localparam t_err ERR_HEADER  = 2'd0;
    localparam t_err ERR_META    = 2'd1;
    localparam t_err ERR_SYSTEM  = 2'd2;
    localparam t_err ERR_RUNNING = 2'd3;

    localparam logic [7:0] BYTE_TERM     = 8'h00;
    localparam logic [7:0] META_TYPE     = 8'hFF;
    localparam logic [7:0] META_NAME     = 8'h03;
    localparam logic [7:0] SYSTEM_BASE   = 8'hF0;
    localparam logic [3:0] PROG_NIBBLE   = 4'hC;
    localparam logic [3:0] PRESS_NIBBLE  = 4'hD;
    localparam logic [3:0] TAG_LENGTH    = 4'd8;
    localparam logic [3:0] TAG_POS_MAX   = 4'd15;

    typedef struct packed {
        t_kind       kind;
        logic [31:0] delta_time;
        logic [7:0]  track_id;
        logic [7:0]  status_byte;
        logic [7:0]  first_data;
        logic [7:0]  second_data;
        logic [1:0]  data_count;
        logic [7:0]  name_byte;
        logic        last_of_name;
        t_err        error_code;
    } t_result;

    function automatic logic [7:0] header_tag(input logic [2:0] idx);
        logic [7:0] ch;
        unique case (idx)
            3'd0:    ch = 8'h4D;
            3'd1:    ch = 8'h69;
            3'd2:    ch = 8'h64;
            3'd3:    ch = 8'h69;
            3'd4:    ch = 8'h53;
            3'd5:    ch = 8'h69;
            3'd6:    ch = 8'h6E;
            default: ch = 8'h6B;
        endcase
        return ch;
    endfunction

endpackage

`default_nettype wire

FILE: hdl/mcp_byte_if.sv
// Input channel: one stream byte per item with valid/ready handshake.
// Depends on nothing.
`default_nettype none

interface mcp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] stream_byte;

    modport source (output valid, output stream_byte, input ready);
    modport sink   (input valid, input stream_byte, output ready);
endinterface

`default_nettype wire

FILE: hdl/mcp_result_if.sv
// Result channel: one parsed result per item with valid/ready handshake.
// Depends on mcp_pkg for the field types.
`default_nettype none

interface mcp_result_if;
    logic               valid;
    logic               ready;
    mcp_pkg::t_kind     kind;
    logic [31:0]        delta_time;
    logic [7:0]         track_id;
    logic [7:0]         status_byte;
    logic [7:0]         first_data;
    logic [7:0]         second_data;
    logic [1:0]         data_count;
    logic [7:0]         name_byte;
    logic               last_of_name;
    mcp_pkg::t_err      error_code;

    modport source (
        output valid, output kind, output delta_time, output track_id,
        output status_byte, output first_data, output second_data,
        output data_count, output name_byte, output last_of_name,
        output error_code, input ready
    );
    modport sink (
        input valid, input kind, input delta_time, input track_id,
        input status_byte, input first_data, input second_data,
        input data_count, input name_byte, input last_of_name,
        input error_code, output ready
    );
endinterface

`default_nettype wire

FILE: hdl/mcp_parser.sv
// Parse state machine: header check, delta time, track, type, meta name
// and channel event bytes. Depends on mcp_pkg.
`default_nettype none

module mcp_parser (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_we,
    input  wire logic             i_cfg_data,
    input  wire logic             i_accept,
    input  wire logic [7:0]       i_byte,
    output logic                  o_res_valid,
    output mcp_pkg::t_result      o_res
);
    import mcp_pkg::*;

    typedef enum logic [3:0] {
        PH_FRESH, PH_TAG, PH_STAMP, PH_DELTA, PH_TRACK, PH_TYPE, PH_META,
        PH_COUNT, PH_NAME, PH_DATA_A, PH_DATA_B, PH_DATA_ONLY, PH_STOP
    } t_phase;

    t_phase      r_phase,  n_phase, ph;
    logic        r_check_header;
    logic [31:0] r_acc,    n_acc;
    logic [7:0]  r_track,  n_track;
    logic [7:0]  r_status, n_status;
    logic [7:0]  r_first,  n_first;
    logic [31:0] r_remain, n_remain;
    logic [3:0]  r_tag_pos, n_tag_pos;
    logic        r_tag_bad, n_tag_bad;
    logic [31:0] count_next;
    logic [31:0] remain_dec;

    assign count_next = {r_remain[24:0], i_byte[6:0]};
    assign remain_dec = r_remain - 32'd1;

    always_comb begin
        n_phase     = r_phase;
        n_acc       = r_acc;
        n_track     = r_track;
        n_status    = r_status;
        n_first     = r_first;
        n_remain    = r_remain;
        n_tag_pos   = r_tag_pos;
        n_tag_bad   = r_tag_bad;
        o_res_valid = 1'b0;
        o_res       = '0;
        ph          = r_phase;
        if (ph == PH_FRESH) begin
            ph = r_check_header ? PH_TAG : PH_DELTA;
        end
        if (i_accept) begin
            n_phase = ph;
            unique case (ph)
                PH_TAG: begin
                    if (i_byte == BYTE_TERM) begin
                        if (r_tag_bad || r_tag_pos != TAG_LENGTH) begin
                            o_res_valid      = 1'b1;
                            o_res.kind       = KIND_ERROR;
                            o_res.error_code = ERR_HEADER;
                            n_phase          = PH_STOP;
                        end else begin
                            n_phase = PH_STAMP;
                        end
                    end else begin
                        if (r_tag_pos >= TAG_LENGTH ||
                            i_byte != header_tag(r_tag_pos[2:0])) begin
                            n_tag_bad = 1'b1;
                        end
                        if (r_tag_pos < TAG_POS_MAX) begin
                            n_tag_pos = r_tag_pos + 4'd1;
                        end
                    end
                end
                PH_STAMP: begin
                    if (i_byte == BYTE_TERM) begin
                        n_acc   = '0;
                        n_phase = PH_DELTA;
                    end
                end
                PH_DELTA: begin
                    n_acc = {r_acc[24:0], i_byte[6:0]};
                    if (!i_byte[7]) begin
                        n_phase = PH_TRACK;
                    end
                end
                PH_TRACK: begin
                    n_track = i_byte;
                    n_phase = PH_TYPE;
                end
                PH_TYPE: begin
                    if (i_byte == META_TYPE) begin
                        n_status = '0;
                        n_phase  = PH_META;
                    end else if (i_byte >= SYSTEM_BASE) begin
                        o_res_valid      = 1'b1;
                        o_res.kind       = KIND_ERROR;
                        o_res.error_code = ERR_SYSTEM;
                        n_phase          = PH_STOP;
                    end else if (!i_byte[7]) begin
                        o_res_valid      = 1'b1;
                        o_res.kind       = KIND_ERROR;
                        o_res.error_code = ERR_RUNNING;
                        n_phase          = PH_STOP;
                    end else begin
                        n_status = i_byte;
                        n_phase  = (i_byte[7:4] == PROG_NIBBLE ||
                                    i_byte[7:4] == PRESS_NIBBLE) ? PH_DATA_ONLY : PH_DATA_A;
                    end
                end
                PH_META: begin
                    if (i_byte != META_NAME) begin
                        o_res_valid      = 1'b1;
                        o_res.kind       = KIND_ERROR;
                        o_res.error_code = ERR_META;
                        n_phase          = PH_STOP;
                    end else begin
                        n_remain = '0;
                        n_phase  = PH_COUNT;
                    end
                end
                PH_COUNT: begin
                    n_remain = count_next;
                    if (!i_byte[7]) begin
                        if (count_next == '0) begin
                            o_res_valid      = 1'b1;
                            o_res.kind       = KIND_EMPTY_NAME;
                            o_res.delta_time = r_acc;
                            o_res.track_id   = r_track;
                            n_acc            = '0;
                            n_phase          = PH_DELTA;
                        end else begin
                            n_phase = PH_NAME;
                        end
                    end
                end
                PH_NAME: begin
                    o_res_valid      = 1'b1;
                    o_res.kind       = KIND_NAME_BYTE;
                    o_res.delta_time = r_acc;
                    o_res.track_id   = r_track;
                    o_res.name_byte  = i_byte;
                    n_remain         = remain_dec;
                    if (remain_dec == '0) begin
                        o_res.last_of_name = 1'b1;
                        n_acc              = '0;
                        n_phase            = PH_DELTA;
                    end
                end
                PH_DATA_A: begin
                    n_first = i_byte;
                    n_phase = PH_DATA_B;
                end
                PH_DATA_B: begin
                    o_res_valid       = 1'b1;
                    o_res.kind        = KIND_EVENT;
                    o_res.delta_time  = r_acc;
                    o_res.track_id    = r_track;
                    o_res.status_byte = r_status;
                    o_res.first_data  = r_first;
                    o_res.second_data = i_byte;
                    o_res.data_count  = 2'd2;
                    n_acc             = '0;
                    n_phase           = PH_DELTA;
                end
                PH_DATA_ONLY: begin
                    o_res_valid       = 1'b1;
                    o_res.kind        = KIND_EVENT;
                    o_res.delta_time  = r_acc;
                    o_res.track_id    = r_track;
                    o_res.status_byte = r_status;
                    o_res.first_data  = i_byte;
                    o_res.data_count  = 2'd1;
                    n_acc             = '0;
                    n_phase           = PH_DELTA;
                end
                default: begin
                    n_phase = r_phase;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= PH_FRESH;
            r_check_header <= 1'b1;
            r_acc          <= '0;
            r_track        <= '0;
            r_status       <= '0;
            r_first        <= '0;
            r_remain       <= '0;
            r_tag_pos      <= '0;
            r_tag_bad      <= 1'b0;
        end else begin
            r_phase   <= n_phase;
            r_acc     <= n_acc;
            r_track   <= n_track;
            r_status  <= n_status;
            r_first   <= n_first;
            r_remain  <= n_remain;
            r_tag_pos <= n_tag_pos;
            r_tag_bad <= n_tag_bad;
            if (i_cfg_we) begin
                r_check_header <= i_cfg_data;
            end
        end
    end

endmodule

`default_nettype wire

FILE: hdl/mcp_out_skid.sv
// Result register with a skid stage so the parser keeps taking items
// while a result waits downstream. Depends on mcp_pkg.
`default_nettype none

module mcp_out_skid (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire mcp_pkg::t_result  i_data,
    output logic                   o_ready,
    output logic                   o_valid,
    output mcp_pkg::t_result       o_data,
    input  wire logic              i_take_ready
);
    import mcp_pkg::*;

    logic    r_out_valid;
    t_result r_out;
    logic    r_skid_valid;
    t_result r_skid;
    logic    take;

    assign take    = r_out_valid & i_take_ready;
    assign o_ready = ~r_skid_valid;
    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || take) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= i_push;
            end
        end else if (i_push) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || take) begin
            r_out <= r_skid_valid ? r_skid : i_data;
        end else if (i_push) begin
            r_skid <= i_data;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/midi_capture_cell_parser.sv
// Capture cell parser top: byte channel in, result channel out.
// A finished result is registered in the output register, or in the skid entry while the output is held.
// Throughput: one byte per cycle; the two-entry result stage stalls input
// only when both entries hold results the sink has not taken.
// Reset: synchronous active low; clears parse state, check_header to 1.
// Depends on mcp_pkg, mcp_byte_if, mcp_result_if, mcp_parser, mcp_out_skid.
`default_nettype none

module midi_capture_cell_parser (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_cfg_we,
    input  wire logic   i_cfg_data,
    mcp_byte_if.sink    i_in,
    mcp_result_if.source o_out
);
    import mcp_pkg::*;

    logic    accept;
    logic    in_ready;
    logic    res_valid;
    t_result res;
    logic    out_valid;
    t_result out_data;

    assign i_in.ready = in_ready;
    assign accept     = i_in.valid & in_ready;

    mcp_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (accept),
        .i_byte      (i_in.stream_byte),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    mcp_out_skid u_out (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (res_valid),
        .i_data       (res),
        .o_ready      (in_ready),
        .o_valid      (out_valid),
        .o_data       (out_data),
        .i_take_ready (o_out.ready)
    );

    assign o_out.valid        = out_valid;
    assign o_out.kind         = out_data.kind;
    assign o_out.delta_time   = out_data.delta_time;
    assign o_out.track_id     = out_data.track_id;
    assign o_out.status_byte  = out_data.status_byte;
    assign o_out.first_data   = out_data.first_data;
    assign o_out.second_data  = out_data.second_data;
    assign o_out.data_count   = out_data.data_count;
    assign o_out.name_byte    = out_data.name_byte;
    assign o_out.last_of_name = out_data.last_of_name;
    assign o_out.error_code   = out_data.error_code;

endmodule

`default_nettype wire
